@@ rtl/core/bsm_pkg.sv @@
package bsm_pkg;

    localparam int COORD_W   = 32;
    localparam int RAD_W     = 31;
    localparam int FRAC_BITS = 16;

    // EPS_RAW is 0, so only equal centres coincide.
    localparam logic [COORD_W:0] EPS_RAW = (COORD_W+1)'((64'd1 << FRAC_BITS) / 64'd100000);

    typedef struct packed {
        logic                      start_req;
        logic signed [COORD_W-1:0] new_center_x;
        logic signed [COORD_W-1:0] new_center_y;
        logic signed [COORD_W-1:0] new_center_z;
        logic signed [COORD_W-1:0] in_radius;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic        [RAD_W-1:0]   radius;
        logic                      valid_res;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQUARE,
        ST_SQRT,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

@@ rtl/core/bounding_sphere_merge.sv @@
// Holds one bounding sphere in signed Q16.16 and grows it so that it also
// encloses each incoming sphere; every accepted word gives one result word
// carrying the held sphere, and the input stalls until that word is taken.
// A word whose radius is not positive, or that arrives while no sphere is
// held, goes from the check straight to the output. When the distance
// alone settles the case (incoming sphere contained, enclosing, or on the
// same centre) a word is accepted, checked, has its squared offsets summed
// on one shared 33x33 multiplier, passes through the bit-serial square
// root, and is then decided and output. In a full merge each of the three
// coordinates also needs a product on the same multiplier and a restoring
// division over all 64 numerator bits, one coordinate after the other.
module bounding_sphere_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bsm_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bsm_pkg::out_word_t  out_data
);

    localparam int CW = bsm_pkg::COORD_W;
    localparam int RW = bsm_pkg::RAD_W;

    bsm_pkg::state_t state_reg, state_next;

    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [RW-1:0]        r_reg;
    logic                 hv_reg;
    logic signed [CW-1:0] nx_reg, ny_reg, nz_reg;
    logic [RW-1:0]        nr_reg;
    logic                 ov_reg;
    logic signed [CW:0]   d_reg [3];
    logic [65:0]          acc_reg;
    logic [32:0]          dist_reg;
    logic [31:0]          grow_reg;
    logic [1:0]           idx_reg;
    logic                 sq_start, div_start, sq_done, div_done;
    logic [32:0]          sq_root, quot;

    logic [32:0]          ma, mb;
    logic [65:0]          mp;
    logic [65:0]          acc_sum;
    logic signed [CW:0]   dsel;
    logic [32:0]          dmag;
    logic [33:0]          s_in, s_held, sum3;
    logic [32:0]          half;
    logic [RW-1:0]        half_sat;
    logic signed [CW-1:0] csel;
    logic signed [CW+1:0] cnew;
    logic                 accept;
    logic                 rad_ok;
    logic                 is_contained, is_enclosing, is_coincident;

    assign in_stall = (state_reg != bsm_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign rad_ok   = !ov_reg && (nr_reg != '0);

    // The one multiplier squares an offset, or scales it by the radius growth.
    always_comb
    begin
        dsel    = d_reg[idx_reg];
        dmag    = dsel[CW] ? 33'(-dsel) : 33'(dsel);
        ma      = dmag;
        mb      = (state_reg == bsm_pkg::ST_MUL) ? {1'b0, grow_reg} : dmag;
        mp      = {33'd0, ma} * {33'd0, mb};
        acc_sum = acc_reg + mp;
    end

    always_comb
    begin
        s_in          = 34'(dist_reg) + 34'(nr_reg);
        s_held        = 34'(dist_reg) + 34'(r_reg);
        sum3          = s_in + 34'(r_reg);
        half          = sum3[33:1];
        half_sat      = (half > 33'({RW{1'b1}})) ? {RW{1'b1}} : half[RW-1:0];
        is_contained  = (s_in <= 34'(r_reg));
        is_enclosing  = (s_held <= 34'(nr_reg));
        is_coincident = (dist_reg <= bsm_pkg::EPS_RAW);
        case (idx_reg)
            2'd0:    csel = cx_reg;
            2'd1:    csel = cy_reg;
            default: csel = cz_reg;
        endcase
        cnew = dsel[CW] ? (CW+2)'(csel) - (CW+2)'(quot)
                        : (CW+2)'(csel) + (CW+2)'(quot);
    end

    bsm_sqrt #(.IN_W(66), .OUT_W(33)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(acc_sum),
        .done(sq_done), .root(sq_root)
    );

    bsm_div #(.N_W(64), .D_W(33), .Q_W(33)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .numer(mp[63:0]),
        .denom(dist_reg), .done(div_done), .quot(quot)
    );

    always_comb
    begin
        state_next = state_reg;
        sq_start   = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            bsm_pkg::ST_IDLE:
                if (accept)
                    state_next = bsm_pkg::ST_CHECK;
            bsm_pkg::ST_CHECK:
                if (rad_ok && hv_reg)
                    state_next = bsm_pkg::ST_SQUARE;
                else
                    state_next = bsm_pkg::ST_OUT;
            bsm_pkg::ST_SQUARE:
                if (idx_reg == 2'd2)
                begin
                    sq_start   = 1'b1;
                    state_next = bsm_pkg::ST_SQRT;
                end
            bsm_pkg::ST_SQRT:
                if (sq_done)
                    state_next = bsm_pkg::ST_DECIDE;
            bsm_pkg::ST_DECIDE:
                if (is_contained || is_enclosing || is_coincident)
                    state_next = bsm_pkg::ST_OUT;
                else
                    state_next = bsm_pkg::ST_MUL;
            bsm_pkg::ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = bsm_pkg::ST_DIV;
            end
            bsm_pkg::ST_DIV:
                if (div_done)
                    state_next = (idx_reg == 2'd2) ? bsm_pkg::ST_OUT : bsm_pkg::ST_MUL;
            bsm_pkg::ST_OUT:
                if (!out_stall)
                    state_next = bsm_pkg::ST_IDLE;
            default:
                state_next = bsm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bsm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            r_reg   <= '0;
            hv_reg  <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                bsm_pkg::ST_IDLE:
                    if (accept && in_data.start_req)
                    begin
                        cx_reg <= '0;
                        cy_reg <= '0;
                        cz_reg <= '0;
                        r_reg  <= '0;
                        hv_reg <= 1'b0;
                    end
                bsm_pkg::ST_CHECK:
                begin
                    idx_reg <= 2'd0;
                    if (rad_ok && !hv_reg)
                    begin
                        cx_reg <= nx_reg;
                        cy_reg <= ny_reg;
                        cz_reg <= nz_reg;
                        r_reg  <= nr_reg;
                        hv_reg <= 1'b1;
                    end
                end
                bsm_pkg::ST_SQUARE:
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                bsm_pkg::ST_DECIDE:
                    if (!is_contained)
                    begin
                        if (is_enclosing)
                        begin
                            cx_reg <= nx_reg;
                            cy_reg <= ny_reg;
                            cz_reg <= nz_reg;
                            r_reg  <= nr_reg;
                        end
                        else if (is_coincident)
                        begin
                            if (nr_reg > r_reg)
                                r_reg <= nr_reg;
                        end
                    end
                bsm_pkg::ST_DIV:
                    if (div_done)
                    begin
                        case (idx_reg)
                            2'd0:    cx_reg <= cnew[CW-1:0];
                            2'd1:    cy_reg <= cnew[CW-1:0];
                            default: cz_reg <= cnew[CW-1:0];
                        endcase
                        if (idx_reg == 2'd2)
                            r_reg <= half_sat;
                        idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    end
                default:
                    ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nx_reg <= in_data.new_center_x;
            ny_reg <= in_data.new_center_y;
            nz_reg <= in_data.new_center_z;
            nr_reg <= in_data.in_radius[RW-1:0];
            ov_reg <= in_data.in_radius[CW-1];
        end
        if (state_reg == bsm_pkg::ST_CHECK)
        begin
            d_reg[0] <= (CW+1)'(nx_reg) - (CW+1)'(cx_reg);
            d_reg[1] <= (CW+1)'(ny_reg) - (CW+1)'(cy_reg);
            d_reg[2] <= (CW+1)'(nz_reg) - (CW+1)'(cz_reg);
            acc_reg  <= '0;
        end
        if (state_reg == bsm_pkg::ST_SQUARE)
            acc_reg <= acc_sum;
        if (state_reg == bsm_pkg::ST_SQRT && sq_done)
            dist_reg <= sq_root;
        if (state_reg == bsm_pkg::ST_DECIDE)
            grow_reg <= 32'(half_sat) - 32'(r_reg);
    end

    assign out_valid          = (state_reg == bsm_pkg::ST_OUT);
    assign out_data.center_x  = cx_reg;
    assign out_data.center_y  = cy_reg;
    assign out_data.center_z  = cz_reg;
    assign out_data.radius    = r_reg;
    assign out_data.valid_res = hv_reg;

endmodule

@@ rtl/core/bsm_sqrt.sv @@
// Restoring integer square root, one result bit per cycle.
module bsm_sqrt #(
    parameter int IN_W  = 66,
    parameter int OUT_W = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IN_W-1:0]  radicand,
    output logic             done,
    output logic [OUT_W-1:0] root
);

    localparam int RW = OUT_W + 2;
    localparam int CW = $clog2(OUT_W + 1);

    logic [2*OUT_W-1:0] rad_reg, rad_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic [OUT_W-1:0]   root_reg, root_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [RW-1:0]      trial;
    logic [RW-1:0]      shifted;

    always_comb
    begin
        shifted   = {rem_reg[RW-3:0], rad_reg[2*OUT_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rad_next  = (2*OUT_W)'(radicand);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(OUT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[OUT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign root = root_next;

endmodule

@@ rtl/core/bsm_div.sv @@
// Restoring divider, one quotient bit per cycle over all N_W numerator bits.
// The quotient is known to fit in Q_W bits, so only those bits are passed out.
module bsm_div #(
    parameter int N_W = 64,
    parameter int D_W = 33,
    parameter int Q_W = 33
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] numer,
    input  logic [D_W-1:0] denom,
    output logic           done,
    output logic [Q_W-1:0] quot
);

    localparam int CW = $clog2(N_W + 1);

    logic [N_W-1:0] num_reg, num_next;
    logic [D_W:0]   rem_reg, rem_next;
    logic [D_W-1:0] den_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [D_W:0]   sh;

    always_comb
    begin
        sh        = {rem_reg[D_W-1:0], num_reg[N_W-1]};
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            num_next  = numer;
            rem_next  = '0;
            cnt_next  = CW'(N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh >= {1'b0, den_reg})
            begin
                rem_next = sh - {1'b0, den_reg};
                num_next = {num_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = sh;
                num_next = {num_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= denom;
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quot = num_next[Q_W-1:0];

endmodule
